### design/cep_pkg.sv
// Shared types, constants and lookup functions for the calendar to epoch
// seconds pipeline. No dependencies; imported by every module of the block.
`default_nettype none

package cep_pkg;

    localparam int S_DATA_W = 40;                 // 34 payload bits, padded to bytes
    localparam int M_DATA_W = 40;                 // 38 payload bits, padded to bytes

    localparam logic [13:0] EPOCH_YEAR         = 14'd1970;
    localparam logic [3:0]  LAST_MONTH_IDX     = 4'd11;
    localparam logic [3:0]  MARCH_IDX          = 4'd2;
    localparam logic [11:0] LEAP_DAYS_TO_EPOCH = 12'd477;  // leap years in 1..1969
    localparam logic [12:0] RECIP_25           = 13'd5243; // 2^17 / 25, rounded up
    localparam int          RECIP_SHIFT        = 17;
    localparam logic [22:0] DAYS_PER_YEAR      = 23'd365;
    localparam logic [40:0] SECS_PER_DAY       = 41'd86400;
    localparam logic [16:0] SECS_PER_HOUR      = 17'd3600;
    localparam logic [16:0] SECS_PER_MINUTE    = 17'd60;

    // Stage 1: clamped date fields and reciprocal products for the /25 steps
    typedef struct packed {
        logic [13:0] yoff;     // year - 1970
        logic [11:0] n_q4;     // (year - 1) / 4
        logic [24:0] p100n;    // ((year - 1) / 4) * RECIP_25
        logic [22:0] p400n;    // ((year - 1) / 16) * RECIP_25
        logic [11:0] y_q4;     // year / 4
        logic [9:0]  y_q16;    // year / 16
        logic [24:0] p100y;
        logic [22:0] p400y;
        logic [3:0]  y_lo;     // year % 16
        logic [3:0]  midx;     // month index, 0 = January
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } s1_t;

    // Stage 2: day terms ready for summing
    typedef struct packed {
        logic [22:0] yday;     // whole years since 1970, in days
        logic [11:0] leapd;    // leap days of earlier years since 1970
        logic [8:0]  mday;     // days of earlier months, this year's Feb 29 included
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } s2_t;

    // Stage 3: signed day count and time-of-day seconds
    typedef struct packed {
        logic [23:0] days;     // two's complement
        logic [16:0] hm;
    } s3_t;

    // Stage 4: day count scaled to seconds
    typedef struct packed {
        logic [40:0] dsec;     // two's complement
        logic [16:0] hm;
    } s4_t;

    // Load enables for the two register stages inside a unit
    typedef struct packed {
        logic first;
        logic second;
    } stage_en_t;

    // Days in the months before month index m, common year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### design/cep_leap_unit.sv
// First two pipeline stages: clamp the date, count leap days and month days.
// Depends on cep_pkg.
`default_nettype none

module cep_leap_unit
    import cep_pkg::*;
(
    input  wire logic        aclk,
    input  wire stage_en_t   en,
    input  wire logic [13:0] year_value,
    input  wire logic [3:0]  month_value,
    input  wire logic [4:0]  day_value,
    input  wire logic [4:0]  hour_value,
    input  wire logic [5:0]  minute_value,
    output s2_t              s2_q
);

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;

    logic [13:0] year_c;
    logic [13:0] year_m1;
    logic [7:0]  q100n, q100y;
    logic [5:0]  q400n, q400y;
    logic        not_cent;
    logic        quad_cent;
    logic        is_leap;

    // Stage 1: clamp, then the reciprocal multiplies for division by 25
    always_comb begin
        year_c  = (year_value < EPOCH_YEAR) ? EPOCH_YEAR : year_value;
        year_m1 = year_c - 14'd1;

        s1_next.yoff  = year_c - EPOCH_YEAR;
        s1_next.n_q4  = year_m1[13:2];
        s1_next.p100n = 25'(year_m1[13:2]) * 25'(RECIP_25);
        s1_next.p400n = 23'(year_m1[13:4]) * 23'(RECIP_25);
        s1_next.y_q4  = year_c[13:2];
        s1_next.y_q16 = year_c[13:4];
        s1_next.p100y = 25'(year_c[13:2]) * 25'(RECIP_25);
        s1_next.p400y = 23'(year_c[13:4]) * 23'(RECIP_25);
        s1_next.y_lo  = year_c[3:0];

        if (month_value == 4'd0) begin
            s1_next.midx = 4'd0;
        end else if (month_value > 4'd12) begin
            s1_next.midx = LAST_MONTH_IDX;
        end else begin
            s1_next.midx = month_value - 4'd1;
        end

        s1_next.day    = day_value;
        s1_next.hour   = hour_value;
        s1_next.minute = minute_value;
    end

    // Stage 2: quotients, leap-year test, day terms
    always_comb begin
        q100n = s1_reg.p100n[RECIP_SHIFT +: 8];
        q400n = s1_reg.p400n[RECIP_SHIFT +: 6];
        q100y = s1_reg.p100y[RECIP_SHIFT +: 8];
        q400y = s1_reg.p400y[RECIP_SHIFT +: 6];

        // year % 100 != 0, given year % 4 == 0
        not_cent  = (12'(q100y) * 12'd25) != s1_reg.y_q4;
        // year % 400 == 0
        quad_cent = (s1_reg.y_lo == 4'd0) && ((10'(q400y) * 10'd25) == s1_reg.y_q16);
        is_leap   = (s1_reg.y_lo[1:0] == 2'd0) && (not_cent || quad_cent);

        s2_next.yday  = 23'(s1_reg.yoff) * DAYS_PER_YEAR;
        s2_next.leapd = s1_reg.n_q4 - 12'(q100n) + 12'(q400n) - LEAP_DAYS_TO_EPOCH;
        s2_next.mday  = days_before_month(s1_reg.midx)
                      + 9'((s1_reg.midx >= MARCH_IDX) && is_leap);
        s2_next.day    = s1_reg.day;
        s2_next.hour   = s1_reg.hour;
        s2_next.minute = s1_reg.minute;
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            s1_reg <= s1_next;
        end
        if (en.second) begin
            s2_reg <= s2_next;
        end
    end

    assign s2_q = s2_reg;

endmodule

`default_nettype wire

### design/cep_seconds_unit.sv
// Stages three and four: sum the day count, scale days to seconds.
// Depends on cep_pkg.
`default_nettype none

module cep_seconds_unit
    import cep_pkg::*;
(
    input  wire logic      aclk,
    input  wire stage_en_t en,
    input  wire s2_t       s2_d,
    output s4_t            s4_q
);

    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;

    // Stage 3: day count (negative only for day zero in January 1970)
    always_comb begin
        s3_next.days = 24'(s2_d.yday) + 24'(s2_d.leapd) + 24'(s2_d.mday)
                     + 24'(s2_d.day) - 24'd1;
        s3_next.hm   = 17'(s2_d.hour) * SECS_PER_HOUR
                     + 17'(s2_d.minute) * SECS_PER_MINUTE;
    end

    // Stage 4: sign-extend and scale
    always_comb begin
        s4_next.dsec = {{17{s3_reg.days[23]}}, s3_reg.days} * SECS_PER_DAY;
        s4_next.hm   = s3_reg.hm;
    end

    always_ff @(posedge aclk) begin
        if (en.first) begin
            s3_reg <= s3_next;
        end
        if (en.second) begin
            s4_reg <= s4_next;
        end
    end

    assign s4_q = s4_reg;

endmodule

`default_nettype wire

### design/calendar_to_epoch_seconds_core.sv
// Top level of the calendar to epoch seconds converter: handshake, valid
// tracking and the final add and clamp. Depends on cep_pkg, cep_leap_unit
// and cep_seconds_unit.
//
// Usage:
//   Slave channel (s_*) takes one Gregorian date and time per transfer;
//   master channel (m_*) returns one epoch-seconds count per transfer, in
//   input order. Years before 1970 count as 1970, month zero as January,
//   months above twelve as December; day, hour and minute add linearly.
//   A negative total clamps to zero, a total beyond 38 bits saturates.
//   Each transfer passes stages 1 to 4, then the output register for m_*.
//   Throughput: one transfer per cycle while m_tready is high; the five-stage
//   pipeline sets it, with the day-to-seconds multiply in a stage of its own.
//   Stall: each stage holds while its successor is full and stalled; an
//   empty stage keeps loading, so bubbles close up and s_tready stays high
//   while any stage is empty. Nothing is dropped or repeated.
//   Reset: synchronous, active low aresetn clears all valid bits; the
//   pipeline accepts in the first cycle after reset is released.
`default_nettype none

module calendar_to_epoch_seconds_core
    import cep_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [13:0] year_value, [17:14] month_value, [22:18] day_value,
    // [27:23] hour_value, [33:28] minute_value, [39:34] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [37:0] epoch_seconds, [39:38] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    // Valid bits of stages 1..4; stage 5 is the output register
    logic [3:0]  vld_reg, vld_next;
    logic        out_vld_reg, out_vld_next;
    logic [37:0] out_reg, out_next;
    logic [4:0]  en;        // en[k] loads stage k+1

    stage_en_t en_leap;
    stage_en_t en_secs;
    s2_t       s2;
    s4_t       s4;
    logic [40:0] total;

    // Load a stage when it is empty or its contents move on this cycle
    always_comb begin
        en[4] = !out_vld_reg || m_tready;
        en[3] = !vld_reg[3] || en[4];
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
    end

    assign s_tready = en[0];

    // Advance valid bits with the data
    always_comb begin
        vld_next[0]  = en[0] ? s_tvalid   : vld_reg[0];
        vld_next[1]  = en[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2]  = en[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3]  = en[3] ? vld_reg[2] : vld_reg[3];
        out_vld_next = en[4] ? vld_reg[3] : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign en_leap = '{first: en[0], second: en[1]};
    assign en_secs = '{first: en[2], second: en[3]};

    cep_leap_unit u_leap (
        .aclk         (aclk),
        .en           (en_leap),
        .year_value   (s_tdata[13:0]),
        .month_value  (s_tdata[17:14]),
        .day_value    (s_tdata[22:18]),
        .hour_value   (s_tdata[27:23]),
        .minute_value (s_tdata[33:28]),
        .s2_q         (s2)
    );

    cep_seconds_unit u_secs (
        .aclk (aclk),
        .en   (en_secs),
        .s2_d (s2),
        .s4_q (s4)
    );

    // Stage 5: add time of day, clamp below zero, saturate above 38 bits
    always_comb begin
        total = s4.dsec + 41'(s4.hm);
        if (total[40]) begin
            out_next = '0;
        end else if (total[39:38] != 2'b00) begin
            out_next = '1;
        end else begin
            out_next = total[37:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg};

`ifndef SYNTHESIS
    // An accepted transfer always lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted input not captured in stage 1");

    // Any empty stage lets the input side take a transfer
    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!(&vld_reg) || !out_vld_reg) |-> s_tready)
        else $error("pipeline has a bubble but s_tready is low");

    // A full stage 4 with a free output moves into the output register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[3] && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("stage 4 item did not reach the output register");

    // With every stage full, a stalled output keeps stage 4 and all behind it from moving
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && (&vld_reg)) |-> !s_tready)
        else $error("input accepted while the full pipeline is stalled");
`endif

endmodule

`default_nettype wire

### verif/tb_calendar_to_epoch_seconds_core.sv
// Self-checking testbench for calendar_to_epoch_seconds_core: streams calendar dates
// through the s_/m_ channels and checks each returned epoch-seconds count against a
// predictor built into this file. Depends on cep_pkg (bus widths) and the core RTL only.
`timescale 1ns / 1ps

module tb_calendar_to_epoch_seconds_core
    import cep_pkg::*;
();

    localparam longint BASE_YEAR      = 1970;
    localparam longint YEAR_DAYS      = 365;
    localparam longint DAY_SECONDS    = 86400;
    localparam longint HOUR_SECONDS   = 3600;
    localparam longint MINUTE_SECONDS = 60;
    localparam longint EPOCH_MAX      = (longint'(1) << 38) - 1;

    localparam int RANDOM_IDLE_DATES = 1200;
    localparam int RANDOM_BURST_DATES = 360;
    localparam int STALL_FILL_DATES  = 48;
    localparam int STALL_RESUME_DATES = 16;
    localparam int SINK_HOLD_LEN     = 300;
    localparam int SETTLE_CYCLES     = 12;
    localparam int TIMEOUT_NS        = 10_000_000;
    localparam int REPORT_LIMIT      = 10;

    // Field order matches s_tdata: year in the lowest bits, minute on top
    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } cal_date_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    logic [37:0] pending_epochs [$];
    logic [37:0] want_epoch;
    int          failures       = 0;
    int          dates_sent     = 0;
    int          results_seen   = 0;
    bit          source_idle_on = 1'b1;
    bit          sink_idle_on   = 1'b1;
    int          sink_hold_cycles = 0;

    calendar_to_epoch_seconds_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the pipeline wedges
    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d dates sent, %0d results seen, %0d still pending",
                 dates_sent, results_seen, pending_epochs.size());
        $display("tb_calendar_to_epoch_seconds_core: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Leap years in 1..n, Gregorian rule
    function automatic longint leaps_upto(longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic bit is_leap_year(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Days in a common year before month m (1 = January), closed form
    function automatic longint days_before(longint m);
        if (m == 1)
            return 0;
        if (m == 2)
            return 31;
        return (153 * (m - 3) + 2) / 5 + 59;
    endfunction

    function automatic logic [37:0] epoch_seconds_of(cal_date_t d);
        longint yr;
        longint mo;
        longint days;
        longint total;
        yr = longint'(d.year);
        mo = longint'(d.month);
        // Clamp year to the epoch and month into 1..12
        if (yr < BASE_YEAR)
            yr = BASE_YEAR;
        if (mo < 1)
            mo = 1;
        if (mo > 12)
            mo = 12;
        days = (yr - BASE_YEAR) * YEAR_DAYS
             + leaps_upto(yr - 1) - leaps_upto(BASE_YEAR - 1)
             + days_before(mo) + longint'(d.day) - 1;
        // This year's Feb 29, once, for months after February
        if (mo > 2 && is_leap_year(yr))
            days = days + 1;
        total = days * DAY_SECONDS + longint'(d.hour) * HOUR_SECONDS
              + longint'(d.minute) * MINUTE_SECONDS;
        // Day zero in January 1970 can go negative; huge years overflow 38 bits
        if (total < 0)
            total = 0;
        if (total > EPOCH_MAX)
            total = EPOCH_MAX;
        return total[37:0];
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic cal_date_t mk_date(int yr, int mo, int dy, int hr, int mi);
        cal_date_t d;
        d.year   = 14'(yr);
        d.month  = 4'(mo);
        d.day    = 5'(dy);
        d.hour   = 5'(hr);
        d.minute = 6'(mi);
        return d;
    endfunction

    function automatic cal_date_t random_date();
        cal_date_t   d;
        int unsigned pick;
        logic [63:0] raw;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // Legal calendar range; day 31 is allowed in every month
            d = mk_date($urandom_range(1970, 9999), $urandom_range(1, 12),
                        $urandom_range(1, 31), $urandom_range(0, 23),
                        $urandom_range(0, 59));
        end else if (pick < 80) begin
            // Straddle Feb 29 in years divisible by 4 or by 100
            if ($urandom_range(0, 1) == 0)
                d.year = 14'(1972 + 4 * $urandom_range(0, 2006));
            else
                d.year = 14'(2000 + 100 * $urandom_range(0, 79));
            d.month  = 4'($urandom_range(2, 3));
            d.day    = (d.month == 4'd2) ? 5'($urandom_range(28, 29))
                                         : 5'($urandom_range(1, 2));
            d.hour   = 5'($urandom_range(0, 23));
            d.minute = 6'($urandom_range(0, 59));
        end else if (pick < 90) begin
            // Near the epoch: clamped year/month, day zero, wild time of day
            d = mk_date($urandom_range(0, 1970), $urandom_range(0, 1),
                        $urandom_range(0, 1), $urandom(), $urandom());
        end else begin
            // Any bit pattern, including saturating years
            raw = {$urandom(), $urandom()};
            d   = raw[$bits(cal_date_t)-1:0];
        end
        return d;
    endfunction

    // Offer one date and hold it until the core takes the transfer
    task automatic send_date(cal_date_t d);
        int unsigned gap;
        gap = source_idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_DATA_W - $bits(cal_date_t)){1'b0}}, d};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_epochs.push_back(epoch_seconds_of(d));
        dates_sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_epochs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic note_failure(string what, logic [37:0] want, logic [37:0] got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // ---------------------------------------------------------------------
    // Result sink: per-result random stall, or a long hold on request
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold_cycles != 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else if (sink_idle_on) begin
                stall = $urandom_range(0, 9);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_epochs.size() == 0) begin
                note_failure("result with nothing pending", '0, m_tdata[37:0]);
            end else begin
                want_epoch = pending_epochs.pop_front();
                if (m_tdata[37:0] !== want_epoch)
                    note_failure("epoch_seconds mismatch", want_epoch, m_tdata[37:0]);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Epoch start, leap-year rule at 4/100/400, month ends, the top legal date
    task automatic test_calendar_extremes();
        send_date(mk_date(1970, 1, 1, 0, 0));
        send_date(mk_date(1970, 1, 1, 0, 1));
        send_date(mk_date(1970, 12, 31, 23, 59));
        send_date(mk_date(1972, 2, 29, 0, 0));
        send_date(mk_date(1972, 3, 1, 0, 0));
        send_date(mk_date(2000, 2, 29, 12, 0));
        send_date(mk_date(2000, 3, 1, 0, 0));
        send_date(mk_date(2100, 2, 28, 23, 59));
        send_date(mk_date(2100, 3, 1, 0, 0));
        send_date(mk_date(2400, 3, 1, 0, 0));
        send_date(mk_date(2023, 2, 31, 6, 30));     // day past the end of February
        send_date(mk_date(2038, 1, 19, 3, 14));
        send_date(mk_date(9999, 12, 31, 23, 59));
        drain_results();
    endtask

    // Clamped year and month, day zero, out-of-range time, zero floor and saturation
    task automatic test_clamp_and_saturation();
        send_date(mk_date(0, 0, 0, 0, 0));          // negative total floors at zero
        send_date(mk_date(1969, 1, 0, 23, 59));     // minus sixty seconds
        send_date(mk_date(1970, 0, 0, 31, 63));     // day zero outweighed by time
        send_date(mk_date(1970, 13, 1, 0, 0));
        send_date(mk_date(1970, 15, 31, 0, 0));
        send_date(mk_date(2024, 6, 15, 31, 63));    // hour and minute do not wrap
        send_date(mk_date(10680, 1, 1, 0, 0));
        send_date(mk_date(10681, 1, 1, 0, 0));
        send_date(mk_date(12000, 6, 1, 0, 0));
        send_date(mk_date(16383, 15, 31, 31, 63));  // every input bit set
        drain_results();
    endtask

    // Random dates with gaps on both sides, then a back-to-back stretch
    task automatic test_random_dates();
        for (int i = 0; i < RANDOM_IDLE_DATES; i++)
            send_date(random_date());
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        for (int i = 0; i < RANDOM_BURST_DATES; i++)
            send_date(random_date());
        drain_results();
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
    endtask

    // Hold the sink for a long stretch so the pipeline fills and s_tready drops,
    // then pause the source until everything has drained and resume
    task automatic test_output_backpressure();
        source_idle_on   = 1'b0;
        sink_idle_on     = 1'b0;
        sink_hold_cycles = SINK_HOLD_LEN;
        for (int i = 0; i < STALL_FILL_DATES; i++)
            send_date(random_date());
        drain_results();
        source_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        for (int i = 0; i < STALL_RESUME_DATES; i++)
            send_date(random_date());
        drain_results();
    endtask

    initial begin : run_tests
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_calendar_extremes();
        test_clamp_and_saturation();
        test_random_dates();
        test_output_backpressure();

        // Let any stray result show up before closing the books
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_epochs.size() != 0) begin
            failures += pending_epochs.size();
            $display("%0d predicted results never arrived", pending_epochs.size());
        end

        $display("covered %0d dates (leap rule, clamps, saturation, random mixes) with %0d",
                 dates_sent, results_seen);
        $display("results checked under random gaps, full rate and a %0d-cycle sink hold",
                 SINK_HOLD_LEN);
        if (failures == 0) begin
            $display("tb_calendar_to_epoch_seconds_core: done, clean");
        end else begin
            $display("%0d failures", failures);
            $display("tb_calendar_to_epoch_seconds_core: done, errors");
        end
        $finish;
    end

endmodule
